### design/psl_pkg.sv
// Package for the probe sphere label counter: sizes, register indexes,
// the command record passed from front to back, and coordinate helpers.
// No dependencies.
package psl_pkg;

    localparam int NUM_PROBES    = 16;
    localparam int MAX_PARTICLES = 4096;
    localparam int COORD_WIDTH   = 32;

    localparam int PI_W      = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
    localparam int LA_W      = $clog2(MAX_PARTICLES);
    localparam int CNT_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_W       = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CYL_RADIUS = 3'd5;

    // Item modes and split codes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_PART   = 1'b1;
    localparam logic SPLIT_PLANE = 1'b0;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef struct packed {
        logic               split_type;
        logic [1:0]         split_axis;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [30:0]        cyl_radius;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [3:0]         probe_slot;
        logic [30:0]        probe_rad;
        logic               label;
        logic               frame_end;
    } t_cmd;

    // Sign-extend the low COORD_WIDTH bits of a coordinate
    function automatic logic signed [31:0] sext(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v << (32 - COORD_WIDTH));
        return t >>> (32 - COORD_WIDTH);
    endfunction

    // Magnitude of a - b, 33 bits
    function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

### design/psl_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module psl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/psl_fifo.sv
// Short command queue between the front and the back.
// Depends on psl_pkg.
module psl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psl_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output psl_pkg::t_cmd o_cmd
);
    import psl_pkg::*;

    t_cmd           r_q [Q_DEPTH];
    logic [Q_W-1:0] r_wp, r_rp;
    logic [Q_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_W+1)'(i_push && !o_full) - (Q_W+1)'(i_pop && !o_empty);
        end
    end
endmodule

### design/psl_front.sv
// Front end: accepts items, labels particles of the first frame, keeps the
// label store and queues commands for the back end. Depends on psl_pkg, psl_ram.
module psl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psl_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  logic [11:0]   i_particle_id,
    input  logic [31:0]   i_pos_x,
    input  logic [31:0]   i_pos_y,
    input  logic [31:0]   i_pos_z,
    input  logic [3:0]    i_probe_slot,
    input  logic [30:0]   i_probe_rad,
    input  logic          i_frame_end,
    output logic          o_push,
    output psl_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import psl_pkg::*;

    typedef enum logic [5:0] {
        F_CLEAR = 6'b000001,
        F_IDLE  = 6'b000010,
        F_DIFF  = 6'b000100,
        F_SQ    = 6'b001000,
        F_CMP   = 6'b010000,
        F_PUSH  = 6'b100000
    } t_fstate;

    t_fstate            r_state;
    t_cmd               r_cmd;
    logic [11:0]        r_pid;
    logic [30:0]        r_dx, r_dy;
    logic               r_far, r_half, r_pending;
    logic [61:0]        r_sqx, r_sqy, r_rr;
    logic [LA_W-1:0]    r_clr;
    logic [LA_W-1:0]    ram_waddr, ram_raddr;
    logic               ram_we, ram_wdata, ram_rdata;
    logic [32:0]        dx, dy;
    logic signed [31:0] c_sel, o_sel;
    logic               lbl, in_range;

    assign o_ready  = (r_state == F_IDLE);
    assign o_push   = (r_state == F_PUSH) && !i_full;
    assign o_cmd    = r_cmd;
    assign in_range = (32'(r_pid) < 32'(MAX_PARTICLES));

    // Label store
    psl_ram #(.WIDTH(1), .DEPTH(MAX_PARTICLES)) u_label (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = (r_state == F_IDLE) ? LA_W'(i_particle_id) : LA_W'(r_pid);

    // Distances to the split origin and axis selection
    always_comb begin
        dx = abs_diff(r_cmd.pos_x, i_cfg.origin_x);
        dy = abs_diff(r_cmd.pos_y, i_cfg.origin_y);
        case (i_cfg.split_axis)
            AXIS_X:  begin c_sel = r_cmd.pos_x; o_sel = i_cfg.origin_x; end
            AXIS_Y:  begin c_sel = r_cmd.pos_y; o_sel = i_cfg.origin_y; end
            default: begin c_sel = r_cmd.pos_z; o_sel = i_cfg.origin_z; end
        endcase
    end

    // Label decision and store write
    always_comb begin
        if (i_cfg.split_type == SPLIT_PLANE) begin
            lbl = r_half;
        end else begin
            lbl = r_far || (64'(r_sqx) + 64'(r_sqy) >= 64'(r_rr));
        end
        ram_we    = 1'b0;
        ram_waddr = LA_W'(r_pid);
        ram_wdata = lbl;
        if (r_state == F_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 1'b0;
        end else if (r_state == F_CMP && r_pending && in_range) begin
            ram_we = 1'b1;
        end
    end

    // Sequence one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_CLEAR;
            r_clr     <= '0;
            r_pending <= 1'b1;
        end else begin
            case (r_state)
                F_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LA_W'(MAX_PARTICLES - 1)) r_state <= F_IDLE;
                end
                F_IDLE: begin
                    if (i_valid) begin
                        r_state <= (i_mode == MODE_LOAD) ? F_PUSH : F_DIFF;
                    end
                end
                F_DIFF: r_state <= F_SQ;
                F_SQ:   r_state <= F_CMP;
                F_CMP:  r_state <= F_PUSH;
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                        if (r_cmd.mode == MODE_PART && r_cmd.frame_end) r_pending <= 1'b0;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_pid            <= i_particle_id;
                r_cmd.mode       <= i_mode;
                r_cmd.pos_x      <= sext(i_pos_x);
                r_cmd.pos_y      <= sext(i_pos_y);
                r_cmd.pos_z      <= sext(i_pos_z);
                r_cmd.probe_slot <= i_probe_slot;
                r_cmd.probe_rad  <= i_probe_rad;
                r_cmd.frame_end  <= i_frame_end;
                r_cmd.label      <= 1'b0;
            end
            F_DIFF: begin
                r_half <= (c_sel >= o_sel);
                r_far  <= dx[32] | dx[31] | dy[32] | dy[31];
                r_dx   <= dx[30:0];
                r_dy   <= dy[30:0];
            end
            F_SQ: begin
                r_sqx <= r_dx * r_dx;
                r_sqy <= r_dy * r_dy;
                r_rr  <= i_cfg.cyl_radius * i_cfg.cyl_radius;
            end
            F_CMP: begin
                if (r_pending) r_cmd.label <= in_range & lbl;
                else           r_cmd.label <= in_range & ram_rdata;
            end
            default: ;
        endcase
    end
endmodule

### design/psl_back.sv
// Back end: holds the probe spheres, runs each particle through a pipelined
// distance unit over all probes, keeps the counts and emits frame results.
// Depends on psl_pkg.
module psl_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  psl_pkg::t_cmd          i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [3:0]             o_probe_number,
    output logic [psl_pkg::CNT_W-1:0] o_colored_count,
    output logic [psl_pkg::CNT_W-1:0] o_particle_count,
    output logic                   o_last_probe
);
    import psl_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_RUN   = 4'b0010,
        B_DRAIN = 4'b0100,
        B_EMIT  = 4'b1000
    } t_bstate;

    t_bstate            r_state;
    t_cmd               r_job;
    logic signed [31:0] r_pcx [NUM_PROBES];
    logic signed [31:0] r_pcy [NUM_PROBES];
    logic signed [31:0] r_pcz [NUM_PROBES];
    logic [30:0]        r_prad [NUM_PROBES];
    logic [CNT_W-1:0]   r_cacc [NUM_PROBES];
    logic [CNT_W-1:0]   r_iacc [NUM_PROBES];
    logic [PI_W-1:0]    r_k, r_k1, r_k2, r_k3, r_e;
    logic               r_v1, r_v2, r_v3;
    logic [30:0]        r_dx, r_dy, r_dz, r_rad1;
    logic               r_far1, r_far2, r_in3;
    logic [61:0]        r_sqx, r_sqy, r_sqz, r_rr;
    logic               r_ovalid;
    logic [3:0]         r_onum;
    logic [CNT_W-1:0]   r_occ, r_opc;
    logic               r_olast;
    logic [32:0]        dx, dy, dz;
    logic               load_ok, out_free;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign load_ok  = (32'(i_cmd.probe_slot) < 32'(NUM_PROBES));
    assign out_free = !r_ovalid || i_ready;

    assign o_valid          = r_ovalid;
    assign o_probe_number   = r_onum;
    assign o_colored_count  = r_occ;
    assign o_particle_count = r_opc;
    assign o_last_probe     = r_olast;

    // Differences to the probe under test
    always_comb begin
        dx = abs_diff(r_job.pos_x, r_pcx[r_k]);
        dy = abs_diff(r_job.pos_y, r_pcy[r_k]);
        dz = abs_diff(r_job.pos_z, r_pcz[r_k]);
    end

    // Probe store writes
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.mode == MODE_LOAD && load_ok) begin
            r_pcx[PI_W'(i_cmd.probe_slot)]  <= i_cmd.pos_x;
            r_pcy[PI_W'(i_cmd.probe_slot)]  <= i_cmd.pos_y;
            r_pcz[PI_W'(i_cmd.probe_slot)]  <= i_cmd.pos_z;
            r_prad[PI_W'(i_cmd.probe_slot)] <= i_cmd.probe_rad;
        end
    end

    // Distance pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_cmd;
        r_k1   <= r_k;
        r_dx   <= dx[30:0];
        r_dy   <= dy[30:0];
        r_dz   <= dz[30:0];
        r_far1 <= dx[32] | dx[31] | dy[32] | dy[31] | dz[32] | dz[31];
        r_rad1 <= r_prad[r_k];
        r_k2   <= r_k1;
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_sqz  <= r_dz * r_dz;
        r_rr   <= r_rad1 * r_rad1;
        r_far2 <= r_far1;
        r_k3   <= r_k2;
        r_in3  <= !r_far2 && (64'(r_sqx) + 64'(r_sqy) + 64'(r_sqz) <= 64'(r_rr));
    end

    // Sequencer, counts and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_k      <= '0;
            r_e      <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_PROBES; i++) begin
                r_cacc[i] <= '0;
                r_iacc[i] <= '0;
            end
        end else begin
            r_v1 <= (r_state == B_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;

            // Load the next result or drop the accepted one
            if (r_state == B_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            // Add one probe's hit
            if (r_v3 && r_in3) begin
                r_iacc[r_k3] <= (r_iacc[r_k3] == CNT_MAX) ? CNT_MAX : r_iacc[r_k3] + 1'b1;
                if (r_job.label && r_cacc[r_k3] != CNT_MAX) begin
                    r_cacc[r_k3] <= r_cacc[r_k3] + 1'b1;
                end
            end

            case (r_state)
                B_IDLE: begin
                    r_k <= '0;
                    if (o_pop && i_cmd.mode == MODE_PART) r_state <= B_RUN;
                end
                B_RUN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == PI_W'(NUM_PROBES - 1)) r_state <= B_DRAIN;
                end
                B_DRAIN: begin
                    r_e <= '0;
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_state <= r_job.frame_end ? B_EMIT : B_IDLE;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_onum       <= 4'(r_e);
                        r_occ        <= r_cacc[r_e];
                        r_opc        <= r_iacc[r_e];
                        r_olast      <= (r_e == PI_W'(NUM_PROBES - 1));
                        r_cacc[r_e]  <= '0;
                        r_iacc[r_e]  <= '0;
                        r_e          <= r_e + 1'b1;
                        if (r_e == PI_W'(NUM_PROBES - 1)) r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

### design/probe_sphere_label_counter.sv
// Top level of the probe sphere label counter: configuration registers and
// the front end, command queue and back end. Depends on psl_pkg and submodules.
//
// After reset the block clears the particle label store and accepts no item
// while it does so (configuration writes are taken). A probe load passes
// the front straight to the queue; a particle passes the front through label
// distance, squaring, compare and queue steps, and at the back it is popped,
// run one probe per cycle through the pipelined distance unit, then drained.
// The back end takes no new particle until it is through with the last one;
// the last particle of a frame adds NUM_PROBES result transactions, one per
// cycle while the sink is ready.
module probe_sphere_label_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [11:0] i_particle_id,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [3:0]  i_probe_slot,
    input  logic [30:0] i_probe_rad,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_probe_number,
    output logic [11:0] o_colored_count,
    output logic [11:0] o_particle_count,
    output logic        o_last_probe
);
    import psl_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, pop_cmd;
    logic push, full, pop, empty;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPLIT_TYPE: r_cfg.split_type <= i_cfg_data[0];
                REG_SPLIT_AXIS: r_cfg.split_axis <= i_cfg_data[1:0];
                REG_ORIGIN_X:   r_cfg.origin_x   <= sext(i_cfg_data);
                REG_ORIGIN_Y:   r_cfg.origin_y   <= sext(i_cfg_data);
                REG_ORIGIN_Z:   r_cfg.origin_z   <= sext(i_cfg_data);
                REG_CYL_RADIUS: r_cfg.cyl_radius <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    psl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_particle_id (i_particle_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_probe_slot  (i_probe_slot),
        .i_probe_rad   (i_probe_rad),
        .i_frame_end   (i_frame_end),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_full        (full)
    );

    psl_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    psl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_cmd            (pop_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_probe_number   (o_probe_number),
        .o_colored_count  (o_colored_count),
        .o_particle_count (o_particle_count),
        .o_last_probe     (o_last_probe)
    );
endmodule

### test/tb.sv
// Self-checking testbench for probe_sphere_label_counter: loads probes, streams
// particle frames and checks per-probe counts against an in-bench predictor.
// Depends on psl_pkg and the design files.
`timescale 1ns / 100ps

module tb;
    import psl_pkg::*;

    localparam logic       SPLIT_RADIAL = 1'b1;
    localparam logic [1:0] AXIS_Z_SEL   = 2'd2;
    localparam logic [1:0] AXIS_ALIAS_Z = 2'd3;
    localparam int         SETTLE       = 60;
    localparam int         LIMIT        = 3000000;
    localparam logic [63:0] DMAX        = 64'h7FFF_FFFF;

    typedef struct {
        logic        mode;
        logic [11:0] pid;
        logic [31:0] x, y, z;
        logic [3:0]  slot;
        logic [30:0] rad;
        logic        fend;
    } t_item;

    typedef struct {
        logic [3:0]  num;
        logic [11:0] colored;
        logic [11:0] count;
        logic        last;
    } t_probe_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [11:0] i_particle_id = '0;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [3:0]  i_probe_slot = '0;
    logic [30:0] i_probe_rad = '0;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_probe_number;
    logic [11:0] o_colored_count;
    logic [11:0] o_particle_count;
    logic        o_last_probe;

    probe_sphere_label_counter u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic               m_split_type = 1'b0;
    logic [1:0]         m_split_axis = '0;
    logic signed [31:0] m_org_x = '0, m_org_y = '0, m_org_z = '0;
    logic [30:0]        m_cyl_rad = '0;
    logic signed [31:0] m_cx [NUM_PROBES];
    logic signed [31:0] m_cy [NUM_PROBES];
    logic signed [31:0] m_cz [NUM_PROBES];
    logic [30:0]        m_rad [NUM_PROBES];
    logic               m_label [MAX_PARTICLES];
    logic               m_labelling = 1'b1;
    logic [11:0]        m_colored [NUM_PROBES];
    logic [11:0]        m_inside [NUM_PROBES];

    t_item      pending_items[$];
    t_probe_res expected_counts[$];
    t_item      cur;
    int         idle_pct = 37;
    bit         hold_send = 1'b0;
    int         fails = 0;
    int         cycles = 0;

    initial begin
        for (int i = 0; i < MAX_PARTICLES; i++) m_label[i] = 1'b0;
        for (int i = 0; i < NUM_PROBES; i++) begin
            m_colored[i] = '0;
            m_inside[i] = '0;
        end
    end

    function automatic logic [63:0] mag(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 64'(-d) : 64'(d);
    endfunction

    // Apply one accepted transaction to the predictor
    task automatic count_item(t_item it);
        logic [63:0] dx, dy, dz, r;
        logic signed [31:0] c, o;
        logic lbl;
        t_probe_res res;
        if (it.mode == MODE_LOAD) begin
            m_cx[it.slot] = it.x;
            m_cy[it.slot] = it.y;
            m_cz[it.slot] = it.z;
            m_rad[it.slot] = it.rad;
            return;
        end
        if (m_labelling) begin
            if (m_split_type == SPLIT_PLANE) begin
                if (m_split_axis == AXIS_X) begin
                    c = it.x; o = m_org_x;
                end else if (m_split_axis == AXIS_Y) begin
                    c = it.y; o = m_org_y;
                end else begin
                    c = it.z; o = m_org_z;
                end
                m_label[it.pid] = (c >= o);
            end else begin
                dx = mag(it.x, m_org_x);
                dy = mag(it.y, m_org_y);
                r = {33'b0, m_cyl_rad};
                if (dx > DMAX || dy > DMAX) m_label[it.pid] = 1'b1;
                else m_label[it.pid] = (dx * dx + dy * dy >= r * r);
            end
        end
        lbl = m_label[it.pid];
        for (int i = 0; i < NUM_PROBES; i++) begin
            dx = mag(it.x, m_cx[i]);
            dy = mag(it.y, m_cy[i]);
            dz = mag(it.z, m_cz[i]);
            r = {33'b0, m_rad[i]};
            if (dx <= DMAX && dy <= DMAX && dz <= DMAX &&
                dx * dx + dy * dy + dz * dz <= r * r) begin
                if (m_inside[i] != CNT_MAX) m_inside[i] = m_inside[i] + 12'd1;
                if (lbl && m_colored[i] != CNT_MAX) m_colored[i] = m_colored[i] + 12'd1;
            end
        end
        if (it.fend) begin
            for (int i = 0; i < NUM_PROBES; i++) begin
                res.num = 4'(i);
                res.colored = m_colored[i];
                res.count = m_inside[i];
                res.last = (i == NUM_PROBES - 1);
                expected_counts = {expected_counts, res};
                m_colored[i] = '0;
                m_inside[i] = '0;
            end
            m_labelling = 1'b0;
        end
    endtask

    // Driver: present the next queued transaction, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) count_item(cur);
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 && !hold_send &&
                    $urandom_range(99) >= idle_pct) begin
                    cur = pending_items.pop_front();
                    i_mode <= cur.mode;
                    i_particle_id <= cur.pid;
                    i_pos_x <= cur.x;
                    i_pos_y <= cur.y;
                    i_pos_z <= cur.z;
                    i_probe_slot <= cur.slot;
                    i_probe_rad <= cur.rad;
                    i_frame_end <= cur.fend;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure and field checks
    always @(posedge i_clk) begin
        t_probe_res e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
            if (o_valid && i_ready) begin
                if (expected_counts.size() == 0) begin
                    $error("unexpected result transaction, probe %0d", o_probe_number);
                    fails++;
                end else begin
                    e = expected_counts.pop_front();
                    if (o_probe_number !== e.num) begin
                        $error("probe_number exp %0d got %0d", e.num, o_probe_number);
                        fails++;
                    end
                    if (o_colored_count !== e.colored) begin
                        $error("colored_count exp %0d got %0d", e.colored, o_colored_count);
                        fails++;
                    end
                    if (o_particle_count !== e.count) begin
                        $error("particle_count exp %0d got %0d", e.count, o_particle_count);
                        fails++;
                    end
                    if (o_last_probe !== e.last) begin
                        $error("last_probe exp %0d got %0d", e.last, o_last_probe);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic add_particle(logic [11:0] pid, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic fend);
        t_item it;
        it = '{MODE_PART, pid, x, y, z, 4'($urandom), 31'($urandom), fend};
        pending_items = {pending_items, it};
    endtask

    task automatic add_probe(logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [30:0] rad);
        t_item it;
        it = '{MODE_LOAD, 12'($urandom), x, y, z, slot, rad, 1'($urandom)};
        pending_items = {pending_items, it};
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(32'h000C_0000)) - 32'sh0006_0000);
    endfunction

    // Sample after the edge settles until the sender is idle and no result is owed
    task automatic wait_quiet(bit all_sent);
        do begin
            @(posedge i_clk);
            #1;
        end while ((all_sent && pending_items.size() != 0) || i_valid ||
                   expected_counts.size() != 0);
    endtask

    // Hold off until everything sent is counted and all results are back
    task automatic drain();
        wait_quiet(1'b1);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_SPLIT_TYPE: m_split_type = data[0];
            REG_SPLIT_AXIS: m_split_axis = data[1:0];
            REG_ORIGIN_X:   m_org_x = data;
            REG_ORIGIN_Y:   m_org_y = data;
            REG_ORIGIN_Z:   m_org_z = data;
            REG_CYL_RADIUS: m_cyl_rad = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random particles for the first, still unfinished frame
    task automatic labelling_batch(int n);
        for (int i = 0; i < n; i++)
            add_particle(12'($urandom), near_coord(), near_coord(), near_coord(), 1'b0);
    endtask

    initial begin
        int nframes, len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: probes, whose loads carry a random frame-end flag
        write_reg(REG_SPLIT_TYPE, {31'b0, SPLIT_PLANE});
        write_reg(REG_SPLIT_AXIS, {30'b0, AXIS_X});
        write_reg(REG_ORIGIN_X, 32'h0);
        add_probe(4'd0, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
        add_probe(4'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        add_probe(4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0);
        for (int s = 3; s < NUM_PROBES; s++)
            add_probe(4'(s), near_coord(), near_coord(), near_coord(),
                      31'($urandom_range(32'h0003_0000)));
        add_particle(12'd0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_particle(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_particle(12'h001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        labelling_batch(4);
        drain();

        // Still the first frame: change the split between batches
        write_reg(REG_SPLIT_AXIS, {30'b0, AXIS_Y});
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        labelling_batch(3);
        drain();
        write_reg(REG_SPLIT_AXIS, {30'b0, AXIS_Z_SEL});
        write_reg(REG_ORIGIN_Z, 32'h7FFF_FFFF);
        add_particle(12'h002, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        labelling_batch(2);
        drain();
        write_reg(REG_SPLIT_AXIS, {30'b0, AXIS_ALIAS_Z});
        write_reg(REG_ORIGIN_Z, 32'h0);
        labelling_batch(3);
        drain();
        write_reg(REG_SPLIT_TYPE, {31'b0, SPLIT_RADIAL});
        write_reg(REG_CYL_RADIUS, 32'h0);
        labelling_batch(2);
        drain();
        write_reg(REG_CYL_RADIUS, 32'h7FFF_FFFF);
        add_particle(12'h003, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
        labelling_batch(2);
        drain();
        write_reg(REG_ORIGIN_X, 32'($urandom));
        write_reg(REG_ORIGIN_Y, 32'($urandom));
        write_reg(REG_CYL_RADIUS, 32'($urandom_range(32'h0004_0000)));
        labelling_batch(3);
        add_particle(12'($urandom), near_coord(), near_coord(), near_coord(), 1'b1);
        drain();

        // Random frames: mostly near the probes, some full-range noise
        write_reg(REG_SPLIT_TYPE, {31'b0, SPLIT_PLANE});
        write_reg(REG_CYL_RADIUS, 32'h7FFF_FFFF);
        idle_pct = 0;
        nframes = 0;
        while (nframes < 14) begin
            if (nframes == 7) begin
                // hold the sender until every result is back
                hold_send = 1'b1;
                wait_quiet(1'b0);
                hold_send = 1'b0;
                idle_pct = 37;
            end
            if ($urandom_range(3) == 0)
                add_probe(4'($urandom), near_coord(), near_coord(), near_coord(),
                          31'($urandom_range(32'h0004_0000)));
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0)
                    add_particle(12'($urandom), $urandom, $urandom, $urandom,
                                 i == len - 1);
                else
                    add_particle(12'($urandom), near_coord(), near_coord(),
                                 near_coord(), i == len - 1);
            end
            if (nframes % 5 == 4) drain();
            nframes++;
        end
        drain();

        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
design/psl_pkg.sv
design/psl_ram.sv
design/psl_fifo.sv
design/psl_front.sv
design/psl_back.sv
design/probe_sphere_label_counter.sv
test/tb.sv
